/* design/fdg_pkg.sv */
// Shared types and constants for the feedback delay with glide.
// Used by fdg_alu, fdg_ring, fdg_checker and feedback_delay_with_glide.
`default_nettype none

package fdg_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int LEN_W      = 15;
	localparam int MIX_W      = 7;
	localparam int GAIN_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam int RING_DEPTH_DEF = 32768;
	localparam int ADDR_SPAN      = 65536;

	localparam logic [LEN_W-1:0]  LENGTH_AT_RESET = 15'd13020;
	localparam logic              ENABLE_RST      = 1'b1;
	localparam logic [LEN_W-1:0]  RING_LAST_RST   = 15'd32760;
	localparam logic [LEN_W-1:0]  TARGET_RST      = 15'd16384;
	localparam logic [MIX_W-1:0]  WET_RST         = 7'd16;
	localparam logic [MIX_W-1:0]  FEEDBACK_RST    = 7'd3;
	localparam logic [GAIN_W-1:0] GAIN_RST        = 8'd38;

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE    = 3'd0,
		CFG_RING_LAST = 3'd1,
		CFG_TARGET    = 3'd2,
		CFG_WET       = 3'd3,
		CFG_FEEDBACK  = 3'd4,
		CFG_GAIN      = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ALU_REDUCE,
		ALU_BLEND,
		ALU_GAIN,
		ALU_AVG
	} alu_op_t;

	typedef struct packed {
		alu_op_t           op;
		logic [GAIN_W-1:0] coef;
	} alu_ctl_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDMOD,
		ST_WRMOD,
		ST_TAP,
		ST_FB,
		ST_WET,
		ST_GAIN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

/* design/feedback_delay_with_glide.sv */
// Top level of the feedback delay with gliding length: sequencer and state.
// Depends on fdg_pkg, fdg_alu and fdg_ring.
//
//   channel  signals                         direction  transaction when
//   in       in_valid in_stall sample_in     to block   in_valid && !in_stall
//   out      out_valid out_stall sample_out  from block out_valid && !out_stall
//   cfg      cfg_valid cfg_ready cfg_index   to block   cfg_valid && cfg_ready
//            cfg_data
//
// Enabled, with S = max(1, log2(65536/RING_DEPTH)), the shared compare-subtract
// unit reduces the read and the write position in S steps each, then tap,
// feedback write, mix and gain follow in that order. Disabled, a sample skips
// the reduction and mixing steps. After reset the ring is cleared before the
// first sample is taken. The output register lets the next sample in while a
// result is stalled.
`default_nettype none

module feedback_delay_with_glide #(
	parameter int RING_DEPTH = fdg_pkg::RING_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [fdg_pkg::SAMPLE_W-1:0]   sample_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [fdg_pkg::SAMPLE_W-1:0]   sample_out,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fdg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [fdg_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int AddrW    = $clog2(RING_DEPTH);
	localparam int RedShift = $clog2(fdg_pkg::ADDR_SPAN / RING_DEPTH);
	localparam int RedSteps = (RedShift == 0) ? 1 : RedShift;
	localparam int ShiftW   = (RedSteps > 1) ? $clog2(RedSteps) : 1;
	localparam logic [AddrW-1:0]  LastAddr = AddrW'(RING_DEPTH - 1);
	localparam logic [ShiftW-1:0] KStart   = ShiftW'(RedSteps - 1);

	fdg_pkg::state_t state_q, state_d;

	logic                              en_q;
	logic [fdg_pkg::LEN_W-1:0]         rli_q;
	logic [fdg_pkg::LEN_W-1:0]         tl_q;
	logic [fdg_pkg::MIX_W-1:0]         wet_q;
	logic [fdg_pkg::MIX_W-1:0]         fb_q;
	logic [fdg_pkg::GAIN_W-1:0]        gain_q;

	logic [AddrW-1:0]                  clr_q;
	logic [fdg_pkg::LEN_W-1:0]         wi_q;
	logic [fdg_pkg::LEN_W-1:0]         cl_q;
	logic signed [fdg_pkg::SAMPLE_W-1:0] held_q;
	logic                              half_q;
	logic [ShiftW-1:0]                 k_q;
	logic                              out_valid_q;

	logic signed [fdg_pkg::SAMPLE_W-1:0] sample_q;
	logic signed [fdg_pkg::SAMPLE_W-1:0] tap_q;
	logic signed [fdg_pkg::SAMPLE_W-1:0] res_q;
	logic signed [fdg_pkg::SAMPLE_W-1:0] out_q;
	logic [15:0]                       red_q;
	logic [AddrW-1:0]                  rd_addr_q;
	logic [AddrW-1:0]                  wr_addr_q;

	fdg_pkg::alu_ctl_t                 alu_ctl;
	logic signed [fdg_pkg::SAMPLE_W-1:0] alu_a;
	logic signed [fdg_pkg::SAMPLE_W-1:0] alu_b;
	logic [fdg_pkg::SAMPLE_W-1:0]      alu_res;

	logic                              mem_we;
	logic [AddrW-1:0]                  mem_waddr;
	logic signed [fdg_pkg::SAMPLE_W-1:0] mem_wdata;
	logic signed [fdg_pkg::SAMPLE_W-1:0] mem_rdata;

	logic [15:0]                       rd_pos;
	logic                              in_take;
	logic                              out_load;
	logic signed [fdg_pkg::SAMPLE_W-1:0] tap_d;

	fdg_alu #(
		.RING_DEPTH (RING_DEPTH),
		.SHIFT_W    (ShiftW)
	) u_alu (
		.ctl     (alu_ctl),
		.opa     (alu_a),
		.opb     (alu_b),
		.red_val (red_q),
		.shift   (k_q),
		.res     (alu_res)
	);

	fdg_ring #(
		.RING_DEPTH (RING_DEPTH),
		.ADDR_W     (AddrW)
	) u_ring (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (rd_addr_q),
		.rd_data (mem_rdata)
	);

	assign in_stall   = (state_q != fdg_pkg::ST_IDLE);
	assign in_take    = in_valid && !in_stall;
	assign out_load   = (state_q == fdg_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	always_comb begin
		rd_pos = {1'b0, wi_q} - {1'b0, cl_q}
			+ ((wi_q < cl_q) ? ({1'b0, rli_q} + 16'd1) : 16'd0);
	end

	always_comb begin
		if (cl_q < tl_q) begin
			tap_d = mem_rdata;
		end else if (cl_q > tl_q) begin
			tap_d = half_q ? held_q : $signed(alu_res);
		end else begin
			tap_d = mem_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdg_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		alu_ctl.op   = fdg_pkg::ALU_REDUCE;
		alu_ctl.coef = '0;
		alu_a        = sample_q;
		alu_b        = tap_q;
		mem_we       = 1'b0;
		mem_waddr    = wr_addr_q;
		mem_wdata    = $signed(alu_res);
		unique case (state_q)
			fdg_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == LastAddr) begin
					state_d = fdg_pkg::ST_IDLE;
				end
			end
			fdg_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = en_q ? fdg_pkg::ST_RDMOD : fdg_pkg::ST_DONE;
				end
			end
			fdg_pkg::ST_RDMOD: begin
				if (k_q == '0) begin
					state_d = fdg_pkg::ST_WRMOD;
				end
			end
			fdg_pkg::ST_WRMOD: begin
				if (k_q == '0) begin
					state_d = fdg_pkg::ST_TAP;
				end
			end
			fdg_pkg::ST_TAP: begin
				alu_ctl.op = fdg_pkg::ALU_AVG;
				alu_a      = held_q;
				alu_b      = mem_rdata;
				state_d    = fdg_pkg::ST_FB;
			end
			fdg_pkg::ST_FB: begin
				alu_ctl.op   = fdg_pkg::ALU_BLEND;
				alu_ctl.coef = {1'b0, fb_q};
				mem_we       = 1'b1;
				state_d      = fdg_pkg::ST_WET;
			end
			fdg_pkg::ST_WET: begin
				alu_ctl.op   = fdg_pkg::ALU_BLEND;
				alu_ctl.coef = {1'b0, wet_q};
				state_d      = fdg_pkg::ST_GAIN;
			end
			fdg_pkg::ST_GAIN: begin
				alu_ctl.op   = fdg_pkg::ALU_GAIN;
				alu_ctl.coef = gain_q;
				alu_a        = res_q;
				state_d      = fdg_pkg::ST_DONE;
			end
			fdg_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = fdg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fdg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= fdg_pkg::ENABLE_RST;
			rli_q       <= fdg_pkg::RING_LAST_RST;
			tl_q        <= fdg_pkg::TARGET_RST;
			wet_q       <= fdg_pkg::WET_RST;
			fb_q        <= fdg_pkg::FEEDBACK_RST;
			gain_q      <= fdg_pkg::GAIN_RST;
			clr_q       <= '0;
			wi_q        <= '0;
			cl_q        <= fdg_pkg::LENGTH_AT_RESET;
			held_q      <= '0;
			half_q      <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					fdg_pkg::CFG_ENABLE:    en_q   <= cfg_data[0];
					fdg_pkg::CFG_RING_LAST: rli_q  <= cfg_data;
					fdg_pkg::CFG_TARGET:    tl_q   <= cfg_data;
					fdg_pkg::CFG_WET:       wet_q  <= cfg_data[fdg_pkg::MIX_W-1:0];
					fdg_pkg::CFG_FEEDBACK:  fb_q   <= cfg_data[fdg_pkg::MIX_W-1:0];
					fdg_pkg::CFG_GAIN:      gain_q <= cfg_data[fdg_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end

			if (state_q == fdg_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AddrW'(1);
			end

			if (in_take) begin
				k_q <= KStart;
			end else if (state_q == fdg_pkg::ST_RDMOD || state_q == fdg_pkg::ST_WRMOD) begin
				k_q <= (k_q == '0) ? KStart : k_q - ShiftW'(1);
			end

			if (state_q == fdg_pkg::ST_TAP) begin
				if (cl_q < tl_q) begin
					held_q <= mem_rdata;
					cl_q   <= cl_q + 15'd1;
				end else if (cl_q > tl_q) begin
					if (!half_q) begin
						held_q <= mem_rdata;
						half_q <= 1'b1;
					end else begin
						half_q <= 1'b0;
						cl_q   <= cl_q - 15'd1;
					end
				end else begin
					held_q <= mem_rdata;
				end
			end

			if (state_q == fdg_pkg::ST_FB) begin
				wi_q <= (wi_q >= rli_q) ? '0 : wi_q + 15'd1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= sample_in;
			res_q    <= sample_in;
			red_q    <= rd_pos;
		end
		if (state_q == fdg_pkg::ST_RDMOD) begin
			if (k_q == '0) begin
				rd_addr_q <= alu_res[AddrW-1:0];
				red_q     <= {1'b0, wi_q};
			end else begin
				red_q <= alu_res;
			end
		end
		if (state_q == fdg_pkg::ST_WRMOD) begin
			red_q <= alu_res;
			if (k_q == '0) begin
				wr_addr_q <= alu_res[AddrW-1:0];
			end
		end
		if (state_q == fdg_pkg::ST_TAP) begin
			tap_q <= tap_d;
		end
		if (state_q == fdg_pkg::ST_WET || state_q == fdg_pkg::ST_GAIN) begin
			res_q <= $signed(alu_res);
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

endmodule

`default_nettype wire

/* design/fdg_alu.sv */
// Shared arithmetic unit: modulo compare-subtract step, mix, gain and average.
// Depends on fdg_pkg.
`default_nettype none

module fdg_alu #(
	parameter int RING_DEPTH = fdg_pkg::RING_DEPTH_DEF,
	parameter int SHIFT_W    = 1
) (
	input  fdg_pkg::alu_ctl_t                    ctl,
	input  logic signed [fdg_pkg::SAMPLE_W-1:0]  opa,
	input  logic signed [fdg_pkg::SAMPLE_W-1:0]  opb,
	input  logic [15:0]                          red_val,
	input  logic [SHIFT_W-1:0]                   shift,
	output logic [fdg_pkg::SAMPLE_W-1:0]         res
);

	localparam logic [16:0] Depth17 = 17'(RING_DEPTH);

	logic signed [16:0] mul_a;
	logic signed [8:0]  mul_b;
	logic signed [25:0] prod;
	logic signed [26:0] prod_x;
	logic signed [26:0] scaled;
	logic signed [26:0] sum;
	logic [15:0]        sat_res;
	logic signed [16:0] avg_sum;
	logic [16:0]        red_ext;
	logic [16:0]        red_sub;
	logic [15:0]        red_res;

	always_comb begin
		if (ctl.op == fdg_pkg::ALU_BLEND) begin
			mul_a = $signed({opb[15], opb}) - $signed({opa[15], opa});
		end else begin
			mul_a = 17'(opa);
		end
		mul_b  = $signed({1'b0, ctl.coef});
		prod   = mul_a * mul_b;
		prod_x = 27'(prod);
		if (ctl.op == fdg_pkg::ALU_BLEND) begin
			scaled = prod_x >>> 6;
			sum    = scaled + 27'(opa);
		end else begin
			scaled = prod_x >>> 5;
			sum    = scaled;
		end
		if (sum > 27'sd32767) begin
			sat_res = fdg_pkg::SAT_MAX;
		end else if (sum < -27'sd32768) begin
			sat_res = fdg_pkg::SAT_MIN;
		end else begin
			sat_res = sum[15:0];
		end

		avg_sum = 17'(opa) + 17'(opb);

		red_ext = {1'b0, red_val};
		red_sub = Depth17 << shift;
		if (red_ext >= red_sub) begin
			red_res = 16'(red_ext - red_sub);
		end else begin
			red_res = red_val;
		end

		unique case (ctl.op)
			fdg_pkg::ALU_REDUCE: res = red_res;
			fdg_pkg::ALU_AVG:    res = avg_sum[16:1];
			default:             res = sat_res;
		endcase
	end

endmodule

`default_nettype wire

/* design/fdg_ring.sv */
// Delay ring storage: one write port, one read port with registered data.
// Depends on fdg_pkg.
`default_nettype none

module fdg_ring #(
	parameter int RING_DEPTH = fdg_pkg::RING_DEPTH_DEF,
	parameter int ADDR_W     = $clog2(RING_DEPTH)
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [ADDR_W-1:0]                   wr_addr,
	input  logic signed [fdg_pkg::SAMPLE_W-1:0] wr_data,
	input  logic [ADDR_W-1:0]                   rd_addr,
	output logic signed [fdg_pkg::SAMPLE_W-1:0] rd_data
);

	logic signed [fdg_pkg::SAMPLE_W-1:0] mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

/* design/fdg_checker.sv */
// Port-level checks for feedback_delay_with_glide, attached by bind.
// Depends on fdg_pkg and the top level's port list.
`default_nettype none

module fdg_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [fdg_pkg::SAMPLE_W-1:0] sample_out
);

	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out))
		else $error("stalled output transaction changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input transaction taken while previous sample in work");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("output transaction without an input transaction");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 2'd2)
		else $error("more than two samples outstanding");

endmodule

bind feedback_delay_with_glide fdg_checker u_fdg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sample_out (sample_out)
);

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for the feedback delay with gliding length: random and directed samples
// against an in-bench echo predictor, with register phases, idling and a long output hold-off.
// Depends on fdg_pkg and feedback_delay_with_glide.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_BUDGET  = 1950;
	localparam int QUIET_CYCLES   = 16;
	localparam int BACKLOG_CYCLES = 300;

	class echo_scoreboard;
		bit                                fx_on;
		bit [fdg_pkg::LEN_W-1:0]           ring_last;
		bit [fdg_pkg::LEN_W-1:0]           aim_len;
		bit [fdg_pkg::MIX_W-1:0]           wet;
		bit [fdg_pkg::MIX_W-1:0]           fb;
		bit [fdg_pkg::GAIN_W-1:0]          gain;
		bit signed [fdg_pkg::SAMPLE_W-1:0] ring [fdg_pkg::RING_DEPTH_DEF];
		bit [fdg_pkg::LEN_W-1:0]           wr_ptr;
		bit [fdg_pkg::LEN_W-1:0]           cur_len;
		bit signed [fdg_pkg::SAMPLE_W-1:0] held;
		bit                                odd_half;
		logic signed [fdg_pkg::SAMPLE_W-1:0] echoes_due [$];
		int errors;
		int checked;

		function new();
			fx_on     = fdg_pkg::ENABLE_RST;
			ring_last = fdg_pkg::RING_LAST_RST;
			aim_len   = fdg_pkg::TARGET_RST;
			wet       = fdg_pkg::WET_RST;
			fb        = fdg_pkg::FEEDBACK_RST;
			gain      = fdg_pkg::GAIN_RST;
			foreach (ring[i])
				ring[i] = '0;
			wr_ptr   = '0;
			cur_len  = fdg_pkg::LENGTH_AT_RESET;
			held     = '0;
			odd_half = 1'b0;
			errors   = 0;
			checked  = 0;
		endfunction

		function void set_register(fdg_pkg::cfg_reg_t idx,
				logic [fdg_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				fdg_pkg::CFG_ENABLE:    fx_on = d[0];
				fdg_pkg::CFG_RING_LAST: ring_last = d[fdg_pkg::LEN_W-1:0];
				fdg_pkg::CFG_TARGET:    aim_len = d[fdg_pkg::LEN_W-1:0];
				fdg_pkg::CFG_WET:       wet = d[fdg_pkg::MIX_W-1:0];
				fdg_pkg::CFG_FEEDBACK:  fb = d[fdg_pkg::MIX_W-1:0];
				fdg_pkg::CFG_GAIN:      gain = d[fdg_pkg::GAIN_W-1:0];
				default:       ;
			endcase
		endfunction

		function int clamp16(int v);
			if (v > fdg_pkg::SAT_MAX)
				return fdg_pkg::SAT_MAX;
			if (v < fdg_pkg::SAT_MIN)
				return fdg_pkg::SAT_MIN;
			return v;
		endfunction

		function int mix(int a, int b, int m);
			int d;
			d = (b - a) * m;
			return clamp16(a + (d >>> 6));
		endfunction

		function logic signed [fdg_pkg::SAMPLE_W-1:0] echo_of(
				logic signed [fdg_pkg::SAMPLE_W-1:0] s);
			int x;
			int tap;
			int pos;
			int wet_v;
			x = s;
			if (!fx_on)
				return s;
			if (wr_ptr < cur_len)
				pos = (int'(wr_ptr) - int'(cur_len) + int'(ring_last) + 1) & 32'h0000_FFFF;
			else
				pos = (int'(wr_ptr) - int'(cur_len)) & 32'h0000_FFFF;
			pos = pos % fdg_pkg::RING_DEPTH_DEF;
			if (cur_len < aim_len) begin
				tap = ring[pos];
				held = ring[pos];
				cur_len++;
			end else if (cur_len > aim_len) begin
				if (!odd_half) begin
					tap = (int'(held) + int'(ring[pos])) >>> 1;
					held = ring[pos];
					odd_half = 1'b1;
				end else begin
					tap = held;
					odd_half = 1'b0;
					cur_len--;
				end
			end else begin
				tap = ring[pos];
				held = ring[pos];
			end
			ring[wr_ptr] = fdg_pkg::SAMPLE_W'(mix(x, tap, fb));
			wr_ptr = (wr_ptr >= ring_last) ? '0 : wr_ptr + 1'b1;
			wet_v = mix(x, tap, wet);
			return fdg_pkg::SAMPLE_W'(clamp16((wet_v * int'(gain)) >>> 5));
		endfunction

		function void note_sample(logic signed [fdg_pkg::SAMPLE_W-1:0] s);
			echoes_due.push_back(echo_of(s));
		endfunction

		function void check_sample(logic signed [fdg_pkg::SAMPLE_W-1:0] got);
			logic signed [fdg_pkg::SAMPLE_W-1:0] want;
			checked++;
			if (echoes_due.size() == 0) begin
				$display("%0t: sample_out expected none, got %0d", $time, got);
				errors++;
			end else begin
				want = echoes_due.pop_front();
				if (want !== got) begin
					$display("%0t: sample_out expected %0d, got %0d", $time, want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic signed [fdg_pkg::SAMPLE_W-1:0] sample_in = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic signed [fdg_pkg::SAMPLE_W-1:0] sample_out;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [fdg_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [fdg_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

	echo_scoreboard sb = new();

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit backlog_req = 1'b0;
	int sent = 0;
	int settings = 0;
	int held_out = 0;
	int held_in = 0;

	feedback_delay_with_glide dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample_out(sample_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_register(fdg_pkg::cfg_reg_t'(cfg_index), cfg_data);
			if (in_valid && !in_stall)
				sb.note_sample(sample_in);
			if (in_valid && in_stall)
				held_in++;
			if (out_valid && !out_stall)
				sb.check_sample(sample_out);
			if (out_stall)
				held_out++;
		end
	end

	initial begin : receiver
		int r;
		forever begin
			if (backlog_req) begin
				out_stall <= 1'b1;
				repeat (BACKLOG_CYCLES) @(posedge clk);
				backlog_req = 1'b0;
			end else if (!rx_idle_on) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_stall <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end else begin
					out_stall <= 1'b1;
					repeat ((r < 94) ? $urandom_range(1, 3) : $urandom_range(12, 40))
						@(posedge clk);
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic write_reg(input fdg_pkg::cfg_reg_t idx, input int v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v[fdg_pkg::CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_config(input int v_en, v_last, v_aim, v_wet, v_fb, v_gain);
		write_reg(fdg_pkg::CFG_ENABLE, v_en);
		write_reg(fdg_pkg::CFG_RING_LAST, v_last);
		write_reg(fdg_pkg::CFG_TARGET, v_aim);
		write_reg(fdg_pkg::CFG_WET, v_wet);
		write_reg(fdg_pkg::CFG_FEEDBACK, v_fb);
		write_reg(fdg_pkg::CFG_GAIN, v_gain);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic play(input logic signed [fdg_pkg::SAMPLE_W-1:0] s);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		gap = 0;
		if (tx_idle_on && r >= 50)
			gap = (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.echoes_due.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int n);
		logic signed [fdg_pkg::SAMPLE_W-1:0] s;
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				s = (r < 1) ? fdg_pkg::SAT_MIN : fdg_pkg::SAT_MAX;
			else if (r < 70)
				s = fdg_pkg::SAMPLE_W'($urandom);
			else
				s = fdg_pkg::SAMPLE_W'($urandom_range(0, 512) - 256);
			play(s);
		end
		settle();
	endtask

	initial begin
		int phase;
		int r;
		int cl;
		int d;
		int en;
		int last;
		int aim;
		int wet_v;
		int fb_v;
		int gain_v;
		int n;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		play(fdg_pkg::SAT_MAX);
		play(fdg_pkg::SAT_MIN);
		play(16'sh0000);
		play(-16'sd1);
		play(16'sd1);
		play(16'sh5555);
		play(-16'sh5556);
		settle();

		program_config(0, fdg_pkg::RING_LAST_RST, fdg_pkg::TARGET_RST, fdg_pkg::WET_RST,
			fdg_pkg::FEEDBACK_RST, fdg_pkg::GAIN_RST);
		play(fdg_pkg::SAT_MIN);
		play(fdg_pkg::SAT_MAX);
		play(16'sd1234);
		settle();

		program_config(1, 1, 32767, 127, 127, 255);
		play(fdg_pkg::SAT_MAX);
		play(fdg_pkg::SAT_MIN);
		play(fdg_pkg::SAT_MAX);
		play(-16'sd7);
		settle();

		cl = sb.cur_len;
		program_config(1, cl - 6, 0, 64, 64, 0);
		play(16'sd100);
		play(-16'sd100);
		play(fdg_pkg::SAT_MAX);
		play(fdg_pkg::SAT_MIN);
		play(16'sd3);
		play(-16'sd3);
		settle();

		cl = sb.cur_len;
		program_config(1, 32767, cl, 0, 0, 32);
		play(fdg_pkg::SAT_MIN);
		play(fdg_pkg::SAT_MAX);
		play(16'sh00FF);
		play(-16'sh0100);
		settle();

		phase = 0;
		while (sent < SAMPLE_BUDGET) begin
			cl = sb.cur_len;
			en = ($urandom_range(0, 99) < 10) ? 0 : 1;
			d = $urandom_range(1, 300);
			r = $urandom_range(0, 99);
			if (r < 10)
				last = 32767;
			else if (r < 20)
				last = $urandom_range(1, 31);
			else
				last = (cl - d - 1 < 1) ? 1 : cl - d - 1;
			r = $urandom_range(0, 99);
			if (r < 35)
				aim = cl;
			else if (r < 65)
				aim = cl + int'($urandom_range(1, 400));
			else if (r < 92)
				aim = cl - int'($urandom_range(1, 400));
			else
				aim = (r < 96) ? 0 : 32767;
			if (aim > 32767)
				aim = 32767;
			if (aim < 0)
				aim = 0;
			wet_v = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 64) : $urandom_range(65, 127);
			fb_v = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 64) : $urandom_range(65, 127);
			gain_v = ($urandom_range(0, 99) < 70) ? $urandom_range(16, 64) : $urandom_range(0, 255);
			program_config(en, last, aim, wet_v, fb_v, gain_v);

			r = $urandom_range(0, 99);
			tx_idle_on = (r >= 20);
			rx_idle_on = (r >= 20);
			if (phase % 7 == 2) begin
				tx_idle_on = 1'b0;
				backlog_req = 1'b1;
			end
			n = $urandom_range(40, 200);
			if (n > SAMPLE_BUDGET - sent)
				n = SAMPLE_BUDGET - sent;
			run_phase(n);
			phase++;
		end

		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		settle();

		if (sb.echoes_due.size() != 0) begin
			$display("%0t: %0d expected samples never arrived", $time, sb.echoes_due.size());
			sb.errors++;
		end
		$display("Run: %0d samples sent, %0d echoes checked, %0d register settings applied.",
			sent, sb.checked, settings);
		$display("Output held off for %0d cycles, input back-pressured for %0d cycles.",
			held_out, held_in);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* feedback_delay_with_glide.f */
design/fdg_pkg.sv
design/fdg_alu.sv
design/fdg_ring.sv
design/feedback_delay_with_glide.sv
design/fdg_checker.sv
tb/tb_top.sv
